// ----- sv/mal_pkg.sv -----
`timescale 1ns / 1ps

package mal_pkg;

    // Table geometry
    localparam int CAPACITY = 128;
    localparam int IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CntW     = $clog2(CAPACITY + 1);
    localparam int AddrBits = 48;

    // Result field widths
    localparam int MatchIdxW = 7;
    localparam int EntryCntW = 8;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_EXEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 hit;
        t_status              status;
        logic [MatchIdxW-1:0] match_index;
        logic [EntryCntW-1:0] entry_count;
    } t_result;

endpackage

// ----- sv/mal_ram.sv -----
`timescale 1ns / 1ps

module mal_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mal_seq.sv -----
`timescale 1ns / 1ps

module mal_seq import mal_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic [1:0]          i_func,
    input  logic [AddrBits-1:0] i_key,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res
);

    t_state              r_state, n_state;
    t_func               r_func, n_func;
    logic [AddrBits-1:0] r_key, n_key;
    logic [CntW-1:0]     r_idx, n_idx;
    logic [CntW-1:0]     r_count, n_count;
    logic                r_found, n_found;
    logic [IdxW-1:0]     r_slot, n_slot;
    t_status             r_status, n_status;

    logic                mem_we;
    logic [IdxW-1:0]     mem_waddr;
    logic [AddrBits-1:0] mem_wdata;
    logic [IdxW-1:0]     mem_raddr;
    logic [AddrBits-1:0] mem_rdata;
    logic [CntW-1:0]     idx_inc;

    mal_ram #(
        .Width (AddrBits),
        .Depth (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_inc = CntW'(r_idx + CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_func   <= n_func;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_slot   <= n_slot;
        r_status <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_key     = r_key;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_slot    = r_slot;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_idx[IdxW-1:0];
        mem_wdata = r_key;
        mem_raddr = r_idx[IdxW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func  = t_func'(i_func);
                    n_key   = i_key;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_slot  = '0;
                    n_state = S_READ;
                end
            end
            // Walk the packed table, one read and one compare per slot
            S_READ: begin
                if (r_idx == r_count) begin
                    n_state = S_EXEC;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (mem_rdata == r_key) begin
                    n_found = 1'b1;
                    n_slot  = r_idx[IdxW-1:0];
                    n_state = S_EXEC;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_READ;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_state  = S_DONE;
                case (r_func)
                    FUNC_LOOKUP: begin
                        n_status = r_found ? ST_OK : ST_ABSENT;
                    end
                    FUNC_ADD: begin
                        if (r_found) begin
                            n_status = ST_PRESENT;
                        end else if (r_count == CntW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[IdxW-1:0];
                            n_count   = CntW'(r_count + CntW'(1));
                        end
                    end
                    FUNC_REMOVE: begin
                        if (!r_found) begin
                            n_status = ST_ABSENT;
                        end else begin
                            n_idx   = CntW'(r_slot);
                            n_state = S_SHIFT_RD;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // Move each later entry down one slot
            S_SHIFT_RD: begin
                mem_raddr = idx_inc[IdxW-1:0];
                if (idx_inc >= r_count) begin
                    n_count = CntW'(r_count - CntW'(1));
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IdxW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = idx_inc;
                n_state   = S_SHIFT_RD;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.hit         = r_found;
    assign o_res.status      = r_status;
    assign o_res.match_index = r_found ? MatchIdxW'(r_slot) : '0;
    assign o_res.entry_count = EntryCntW'(r_count);

endmodule

// ----- sv/mac_address_allow_list_core.sv -----
`timescale 1ns / 1ps
// Allow list of 48-bit device addresses, kept packed and in insertion order.
// Request channel: i_in_valid / o_in_ready with i_func (0 lookup, 1 add,
// 2 remove, 3 clear) and i_mac_address. Result channel: o_out_valid /
// i_out_ready with o_hit, o_status, o_match_index and o_entry_count.
// Every request yields exactly one result.
// One request is worked at a time. The table sits in a single-port-read
// RAM with registered read; the search examines each stored entry in two
// steps (address, then compare) and stops at the first match or after the
// last stored entry; a remove then moves each later entry down one slot
// with a read and a write. The next request is taken only after the
// result has entered the output register. A stalled receiver holds the
// result in the output register while the next request is worked; once
// that one is done too, the engine stalls.
// Reset empties the table at once (count to zero); no clearing pass.
module mac_address_allow_list_core import mal_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_func,
    input  logic [AddrBits-1:0]  i_mac_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic [1:0]           o_status,
    output logic [MatchIdxW-1:0] o_match_index,
    output logic [EntryCntW-1:0] o_entry_count
);

    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    mal_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_mac_address),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Advance a result into the output register when it is empty or draining
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out.hit;
    assign o_status      = r_out.status;
    assign o_match_index = r_out.match_index;
    assign o_entry_count = r_out.entry_count;

endmodule
